// File: rtl/core/pls_pkg.sv
// Shared constants, codes and payload types of the positional list store.
package pls_pkg;

    localparam int CAPACITY = 128;
    localparam int IW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int PW       = 8;
    localparam int SW       = ((CW > PW) ? CW : PW) + 1;
    localparam int GRP      = 16;
    localparam int GIW      = $clog2(GRP);
    localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;
    localparam int NGW      = (NGRP > 1) ? $clog2(NGRP) : 1;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_LOCATE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BADPOS   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [2:0] CELL_HOLD   = 3'd0;
    localparam logic [2:0] CELL_INSERT = 3'd1;
    localparam logic [2:0] CELL_DELETE = 3'd2;
    localparam logic [2:0] CELL_READ   = 3'd3;
    localparam logic [2:0] CELL_LOCATE = 3'd4;

    typedef struct packed {
        logic [1:0]         op;
        logic [PW-1:0]      position;
        logic signed [31:0] value;
    } pls_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [PW-1:0]      found_position;
        logic [PW-1:0]      count;
    } pls_out_t;

    typedef struct packed {
        logic [2:0]         code;
        logic [SW-1:0]      slot;
        logic [CW-1:0]      cnt;
        logic signed [31:0] value;
    } pls_cmd_t;

    typedef struct packed {
        logic               any;
        logic [IW-1:0]      idx;
        logic signed [31:0] value;
    } pls_find_t;

endpackage

// File: rtl/core/positional_list_store_top.sv
// Positional list store: a row of entry cells with insert/delete shifting and probing.
// Flow: a taken request passes the EXEC, GRP, FIN and OUT states; the result beat is registered
// out of OUT once the result slot is free. A new request is taken only in the idle state, so each
// request finishes the cell update and the two-level registered hit reduction before the next.
// Reset: entry count clears to zero; cell entries are not cleared and need no sweep.
// A result beat may wait on rsp_stall while the next request is already accepted.
module positional_list_store_top
    import pls_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  pls_in_t  req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output pls_out_t rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_GRP  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    pls_in_t            req_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;
    pls_out_t           rsp_reg;
    pls_out_t           rsp_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;

    pls_cmd_t           cmd;
    logic [SW-1:0]      pos_s;
    logic [SW-1:0]      cnt_s;
    logic               pos_zero;
    logic               ins_pos_ok;
    logic               acc_pos_ok;
    logic               is_full;
    logic               req_take;
    logic               rsp_free;

    logic signed [31:0] entry [CAPACITY];
    logic [CAPACITY-1:0] hit;
    pls_find_t          find;

    assign req_take = req_valid && !req_stall;
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    assign pos_s      = SW'(req_reg.position);
    assign cnt_s      = SW'(count_reg);
    assign pos_zero   = (req_reg.position == '0);
    assign ins_pos_ok = !pos_zero && (pos_s <= cnt_s + SW'(1));
    assign acc_pos_ok = !pos_zero && (pos_s <= cnt_s);
    assign is_full    = (count_reg == CW'(CAPACITY));

    always_comb
    begin
        cmd         = '0;
        cmd.code    = CELL_HOLD;
        cmd.slot    = pos_s - SW'(1);
        cmd.cnt     = count_reg;
        cmd.value   = req_reg.value;
        count_next  = count_reg;
        status_next = status_reg;
        if (state_reg == S_EXEC)
        begin
            status_next = ST_OK;
            unique case (req_reg.op)
                OP_INSERT:
                begin
                    if (!ins_pos_ok)
                    begin
                        status_next = ST_BADPOS;
                    end
                    else if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.code   = CELL_INSERT;
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_DELETE:
                begin
                    if (!acc_pos_ok)
                    begin
                        status_next = ST_BADPOS;
                    end
                    else
                    begin
                        cmd.code   = CELL_DELETE;
                        count_next = count_reg - CW'(1);
                    end
                end
                OP_READ:
                begin
                    if (!acc_pos_ok)
                    begin
                        status_next = ST_BADPOS;
                    end
                    else
                    begin
                        cmd.code = CELL_READ;
                    end
                end
                OP_LOCATE:
                begin
                    cmd.code = CELL_LOCATE;
                end
            endcase
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [31:0] left_w;
        logic signed [31:0] right_w;
        if (i == 0)
        begin : g_first
            assign left_w = entry[i];
        end
        else
        begin : g_mid_l
            assign left_w = entry[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = entry[i];
        end
        else
        begin : g_mid_r
            assign right_w = entry[i+1];
        end
        pls_cell u_cell (
            .clk   (clk),
            .idx   (IW'(i)),
            .cmd   (cmd),
            .left  (left_w),
            .right (right_w),
            .entry (entry[i]),
            .hit   (hit[i])
        );
    end

    pls_reduce u_reduce (
        .clk      (clk),
        .en_group (state_reg == S_GRP),
        .en_final (state_reg == S_FIN),
        .hit      (hit),
        .entry    (entry),
        .find     (find)
    );

    always_comb
    begin
        state_next     = state_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_GRP;
            end
            S_GRP:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (rsp_free)
                begin
                    rsp_next.status         = status_reg;
                    rsp_next.read_value     = '0;
                    rsp_next.found_position = '0;
                    rsp_next.count          = PW'(count_reg);
                    if (req_reg.op == OP_READ && status_reg == ST_OK)
                    begin
                        rsp_next.read_value = find.value;
                    end
                    if (req_reg.op == OP_LOCATE)
                    begin
                        if (find.any)
                        begin
                            rsp_next.found_position = PW'(CW'(find.idx) + CW'(1));
                        end
                        else
                        begin
                            rsp_next.status = ST_NOTFOUND;
                        end
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg <= req;
        end
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: rtl/core/pls_cell.sv
// One list slot: holds an entry, shifts with its neighbors, flags a probe hit.
module pls_cell
    import pls_pkg::*;
(
    input  logic               clk,
    input  logic [IW-1:0]      idx,
    input  pls_cmd_t           cmd,
    input  logic signed [31:0] left,
    input  logic signed [31:0] right,
    output logic signed [31:0] entry,
    output logic               hit
);

    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;
    logic               hit_reg;
    logic               hit_next;
    logic [SW-1:0]      idx_s;

    assign idx_s = SW'(idx);

    always_comb
    begin
        entry_next = entry_reg;
        hit_next   = 1'b0;
        unique case (cmd.code)
            CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            CELL_INSERT:
            begin
                if (idx_s > cmd.slot)
                begin
                    entry_next = left;
                end
                else if (idx_s == cmd.slot)
                begin
                    entry_next = cmd.value;
                end
            end
            CELL_DELETE:
            begin
                if (idx_s >= cmd.slot)
                begin
                    entry_next = right;
                end
            end
            CELL_READ:
            begin
                hit_next = (idx_s == cmd.slot);
            end
            CELL_LOCATE:
            begin
                hit_next = (CW'(idx) < cmd.cnt) && (entry_reg == cmd.value);
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        hit_reg   <= hit_next;
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

// File: rtl/core/pls_reduce.sv
// Two-level registered priority tree: first hit position and its entry.
module pls_reduce
    import pls_pkg::*;
(
    input  logic               clk,
    input  logic               en_group,
    input  logic               en_final,
    input  logic [CAPACITY-1:0] hit,
    input  logic signed [31:0] entry [CAPACITY],
    output pls_find_t          find
);

    logic [NGRP*GRP-1:0] hit_pad;
    logic signed [31:0]  ent_pad [NGRP*GRP];

    logic                g_any_reg  [NGRP];
    logic                g_any_next [NGRP];
    logic [GIW-1:0]      g_idx_reg  [NGRP];
    logic [GIW-1:0]      g_idx_next [NGRP];
    logic signed [31:0]  g_val_reg  [NGRP];
    logic signed [31:0]  g_val_next [NGRP];

    pls_find_t           find_reg;
    pls_find_t           find_next;

    for (genvar k = 0; k < NGRP * GRP; k++)
    begin : g_pad
        if (k < CAPACITY)
        begin : g_real
            assign hit_pad[k] = hit[k];
            assign ent_pad[k] = entry[k];
        end
        else
        begin : g_fill
            assign hit_pad[k] = 1'b0;
            assign ent_pad[k] = '0;
        end
    end

    // lowest hit within each group
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            g_any_next[g] = 1'b0;
            g_idx_next[g] = '0;
            g_val_next[g] = '0;
            for (int j = GRP - 1; j >= 0; j--)
            begin
                if (hit_pad[g*GRP + j])
                begin
                    g_any_next[g] = 1'b1;
                    g_idx_next[g] = GIW'(j);
                    g_val_next[g] = ent_pad[g*GRP + j];
                end
            end
        end
    end

    // lowest group with a hit
    always_comb
    begin
        find_next = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (g_any_reg[g])
            begin
                find_next.any   = 1'b1;
                find_next.idx   = IW'({NGW'(g), g_idx_reg[g]});
                find_next.value = g_val_reg[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_group)
        begin
            for (int g = 0; g < NGRP; g++)
            begin
                g_any_reg[g] <= g_any_next[g];
                g_idx_reg[g] <= g_idx_next[g];
                g_val_reg[g] <= g_val_next[g];
            end
        end
        if (en_final)
        begin
            find_reg <= find_next;
        end
    end

    assign find = find_reg;

endmodule

// File: rtl/core/pls_checker.sv
// Port-level checks on the positional list store, bound to the top level.
module pls_checker
    import pls_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_stall,
    input logic     rsp_valid,
    input logic     rsp_stall,
    input pls_out_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while previous one in flight");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.count <= PW'(CAPACITY)))
        else $error("count exceeds capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |-> rsp.count == PW'(CAPACITY))
        else $error("full status with list not full");

    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.read_value == '0 && rsp.found_position == '0)
        else $error("data fields set on failed request");

endmodule

bind positional_list_store_top pls_checker u_pls_checker (.*);

// File: tb/list_store_checker.sv
// Checker for the positional list store: mirrors the list, predicts each result and compares.
module list_store_checker
    import pls_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_stall,
    input  pls_in_t  req,
    input  logic     rsp_valid,
    input  logic     rsp_stall,
    input  pls_out_t rsp,
    output int       mismatch_count,
    output int       results_owed
);

    logic signed [31:0] list_entries [CAPACITY];
    int                 list_length;
    int                 errors = 0;
    pls_out_t           expected_results [$];

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        errors++;
        if (errors <= 10)
        begin
            $display("mismatch %0d: %s expected %h, got %h", errors, what, want, got);
        end
    endtask

    function automatic pls_out_t apply_list_request(input pls_in_t item);
        pls_out_t res;
        int       pos;
        int       k;
        pos = int'(item.position);
        res = '0;
        res.status = ST_OK;
        case (item.op)
            OP_INSERT:
            begin
                if (pos < 1 || pos > list_length + 1)
                    res.status = ST_BADPOS;
                else if (list_length >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    for (k = list_length; k >= pos; k--)
                        list_entries[k] = list_entries[k - 1];
                    list_entries[pos - 1] = item.value;
                    list_length++;
                end
            end
            OP_DELETE:
            begin
                if (pos < 1 || pos > list_length)
                    res.status = ST_BADPOS;
                else
                begin
                    for (k = pos; k < list_length; k++)
                        list_entries[k - 1] = list_entries[k];
                    list_length--;
                end
            end
            OP_READ:
            begin
                if (pos < 1 || pos > list_length)
                    res.status = ST_BADPOS;
                else
                    res.read_value = list_entries[pos - 1];
            end
            default:
            begin
                res.status = ST_NOTFOUND;
                for (k = 0; k < list_length; k++)
                begin
                    if (list_entries[k] == item.value)
                    begin
                        res.found_position = PW'(k + 1);
                        res.status = ST_OK;
                        break;
                    end
                end
            end
        endcase
        res.count = PW'(list_length);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pls_out_t want;
        if (!rst_n)
        begin
            list_length = 0;
            expected_results.delete();
            mismatch_count <= errors;
            results_owed <= 0;
        end
        else
        begin
            // older result leaves before the new request is queued
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_results.size() == 0)
                    note_mismatch("result beat with none owed", 32'd0, 32'd1);
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.status !== want.status)
                        note_mismatch("status", 32'(want.status), 32'(rsp.status));
                    if (rsp.read_value !== want.read_value)
                        note_mismatch("read_value", want.read_value, rsp.read_value);
                    if (rsp.found_position !== want.found_position)
                        note_mismatch("found_position", 32'(want.found_position),
                                      32'(rsp.found_position));
                    if (rsp.count !== want.count)
                        note_mismatch("count", 32'(want.count), 32'(rsp.count));
                end
            end
            if (req_valid && !req_stall)
                expected_results.push_back(apply_list_request(req));
            mismatch_count <= errors;
            results_owed <= expected_results.size();
        end
    end

endmodule

// File: tb/testbench.sv
// Testbench top for the positional list store: clock, reset, request and result traffic, verdict.
module testbench;
    import pls_pkg::*;

    localparam int MODE_FILL   = 0;
    localparam int MODE_GROW   = 1;
    localparam int MODE_SHRINK = 2;
    localparam int MODE_MIX    = 3;

    localparam int RANDOM_ITEMS = 500;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    pls_in_t  req;
    logic     rsp_valid;
    logic     rsp_stall;
    pls_out_t rsp;

    int mismatch_count;
    int results_owed;
    int beats_sent = 0;
    int list_length = 0;
    int random_sent = 0;
    bit no_gaps = 1'b0;
    bit pressure_done = 1'b0;

    positional_list_store_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    list_store_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("testbench: errors");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3, 4: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input pls_in_t item);
        int gap;
        int pos;
        req_valid <= 1'b1;
        req <= item;
        do @(posedge clk); while (req_stall);
        beats_sent++;
        pos = int'(item.position);
        if (item.op == OP_INSERT && pos >= 1 && pos <= list_length + 1
            && list_length < CAPACITY)
            list_length++;
        else if (item.op == OP_DELETE && pos >= 1 && pos <= list_length)
            list_length--;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_op(input logic [1:0] op, input int pos, input logic [31:0] val);
        pls_in_t item;
        item.op = op;
        item.position = PW'(pos);
        item.value = val;
        send_request(item);
    endtask

    function automatic pls_in_t make_request(input int mode);
        pls_in_t item;
        int      r;
        int      ins_th;
        int      del_th;
        int      rd_th;
        case (mode)
            MODE_FILL:   begin ins_th = 100; del_th = 100; rd_th = 100; end
            MODE_GROW:   begin ins_th = 60;  del_th = 70;  rd_th = 85;  end
            MODE_SHRINK: begin ins_th = 10;  del_th = 70;  rd_th = 85;  end
            default:     begin ins_th = 25;  del_th = 50;  rd_th = 75;  end
        endcase
        r = $urandom_range(0, 99);
        if (r < ins_th)
            item.op = OP_INSERT;
        else if (r < del_th)
            item.op = OP_DELETE;
        else if (r < rd_th)
            item.op = OP_READ;
        else
            item.op = OP_LOCATE;
        if (mode != MODE_FILL && $urandom_range(0, 99) < 15)
            item.position = PW'($urandom_range(0, 255));
        else if (item.op == OP_INSERT)
            item.position = PW'($urandom_range(1, list_length + 1));
        else if (list_length == 0)
            item.position = PW'(1);
        else
            item.position = PW'($urandom_range(1, list_length));
        item.value = pick_value();
        return item;
    endfunction

    // result side: free runs, choppy stalls, rare long holds, one pressure hold
    initial
    begin
        int span;
        rsp_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!pressure_done && beats_sent >= 200)
            begin
                pressure_done = 1'b1;
                rsp_stall <= 1'b1;
                repeat (300) @(posedge clk);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    span = $urandom_range(5, 60);
                    rsp_stall <= 1'b0;
                    repeat (span) @(posedge clk);
                end
                9:
                begin
                    span = $urandom_range(10, 40);
                    rsp_stall <= 1'b1;
                    repeat (span) @(posedge clk);
                end
                default:
                begin
                    span = $urandom_range(5, 40);
                    repeat (span)
                    begin
                        rsp_stall <= ($urandom_range(0, 99) < 35);
                        @(posedge clk);
                    end
                end
            endcase
        end
    end

    initial
    begin
        int mode;
        int seg;
        req_valid <= 1'b0;
        req <= '0;
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, bad positions, extremes, first match, ends and middle
        send_op(OP_LOCATE, 0, 32'd0);
        send_op(OP_READ, 1, 32'd0);
        send_op(OP_DELETE, 1, 32'd0);
        send_op(OP_INSERT, 0, 32'd5);
        send_op(OP_INSERT, 2, 32'd5);
        send_op(OP_INSERT, 1, 32'h7FFF_FFFF);
        send_op(OP_INSERT, 1, 32'h8000_0000);
        send_op(OP_INSERT, 3, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 2, 32'd0);
        send_op(OP_INSERT, 4, 32'd0);
        send_op(OP_LOCATE, 0, 32'd0);
        send_op(OP_LOCATE, 0, 32'hFFFF_FFFF);
        send_op(OP_LOCATE, 0, 32'h8000_0000);
        send_op(OP_LOCATE, 0, 32'd12345);
        send_op(OP_READ, 1, 32'd0);
        send_op(OP_READ, 5, 32'd0);
        send_op(OP_READ, 6, 32'd0);
        send_op(OP_READ, 255, 32'hFFFF_FFFF);
        send_op(OP_DELETE, 6, 32'd0);
        send_op(OP_DELETE, 5, 32'd0);
        send_op(OP_DELETE, 1, 32'd0);
        send_op(OP_DELETE, 2, 32'd0);
        send_op(OP_INSERT, 128, 32'd7);
        send_op(OP_LOCATE, 255, 32'h7FFF_FFFF);

        // fill to capacity, then full and bad-ahead-of-full inserts
        while (list_length < CAPACITY)
        begin
            send_request(make_request(MODE_FILL));
            random_sent++;
        end
        send_op(OP_INSERT, CAPACITY + 1, pick_value());
        send_op(OP_INSERT, 1, pick_value());
        send_op(OP_INSERT, CAPACITY + 2, pick_value());

        while (random_sent < RANDOM_ITEMS)
        begin
            mode = $urandom_range(MODE_GROW, MODE_MIX);
            seg = $urandom_range(40, 80);
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (seg)
            begin
                send_request(make_request(mode));
                random_sent++;
            end
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
